@@ design/flc_pkg.sv @@
// ----------------------------------------------------------------------------
// flc_pkg
// Shared types and constants of the fixed-point linear convolution unit.
// ----------------------------------------------------------------------------
package flc_pkg;

  localparam int MAX_LEN  = 32;
  localparam int LEN_W    = 6;
  localparam int ADDR_W   = $clog2(MAX_LEN);
  localparam int DATA_W   = 32;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int FRAC_W   = 5;
  localparam int CFG_W    = 6;
  localparam int REG_IDX_W = 2;

  typedef enum logic [1:0] {
    ACT_LOAD_SIG = 2'd0,
    ACT_LOAD_KER = 2'd1,
    ACT_COMPUTE  = 2'd2,
    ACT_NONE     = 2'd3
  } flc_action_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FRAC_BITS     = 2'd0,
    REG_SIGNAL_LENGTH = 2'd1,
    REG_KERNEL_LENGTH = 2'd2,
    REG_OUTPUT_LENGTH = 2'd3
  } flc_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } flc_state_e;

  typedef struct packed {
    flc_action_e              action;
    logic [ADDR_W-1:0]        index;
    logic signed [DATA_W-1:0] value;
  } flc_in_t;

  typedef struct packed {
    logic [LEN_W-1:0]         out_index;
    logic signed [DATA_W-1:0] out_value;
    logic                     last;
  } flc_out_t;

  typedef struct packed {
    logic [FRAC_W-1:0] frac_bits;
    logic [LEN_W-1:0]  signal_length;
    logic [LEN_W-1:0]  kernel_length;
    logic [LEN_W-1:0]  output_length;
  } flc_cfg_t;

  typedef struct packed {
    logic              wr_sig;
    logic              wr_ker;
    logic              issue;
    logic              first;
    logic              fin;
    logic              zero;
    logic              lastout;
    logic [LEN_W-1:0]  n;
    logic [ADDR_W-1:0] k_addr;
    logic [ADDR_W-1:0] j_addr;
  } flc_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } flc_status_t;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             fin;
    logic             zero;
    logic             lastout;
    logic [LEN_W-1:0] n;
  } flc_tag_t;

endpackage

@@ design/flc_cfg.sv @@
// ----------------------------------------------------------------------------
// flc_cfg
// Configuration register file: fractional bits and the three lengths.
// ----------------------------------------------------------------------------
module flc_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  flc_pkg::flc_reg_e            cfg_idx_i,
  input  logic [flc_pkg::CFG_W-1:0]    cfg_wdata_i,
  output flc_pkg::flc_cfg_t            cfg_o
);
  import flc_pkg::*;

  flc_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAC_BITS:     cfg_d.frac_bits     = cfg_wdata_i[FRAC_W-1:0];
        REG_SIGNAL_LENGTH: cfg_d.signal_length = cfg_wdata_i[LEN_W-1:0];
        REG_KERNEL_LENGTH: cfg_d.kernel_length = cfg_wdata_i[LEN_W-1:0];
        REG_OUTPUT_LENGTH: cfg_d.output_length = cfg_wdata_i[LEN_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frac_bits     <= FRAC_W'(15);
      cfg_q.signal_length <= '0;
      cfg_q.kernel_length <= '0;
      cfg_q.output_length <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/flc_ctrl.sv @@
// ----------------------------------------------------------------------------
// flc_ctrl
// Controller: decodes commands and walks output positions and terms.
// ----------------------------------------------------------------------------
module flc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  flc_pkg::flc_action_e  action_i,
  input  flc_pkg::flc_cfg_t     cfg_i,
  input  flc_pkg::flc_status_t  status_i,
  output flc_pkg::flc_cmd_t     cmd_o,
  output logic                  busy_o
);
  import flc_pkg::*;

  flc_state_e       state_q, state_d;
  logic [LEN_W-1:0] n_q, n_d, k_q, k_d;
  logic [LEN_W-1:0] slen_c, klen_c, k_lo, k_hi, k_end, n_nxt, j_full;
  logic             empty, fin, accept;

  function automatic logic [LEN_W-1:0] term_lo(input logic [LEN_W-1:0] n,
                                               input logic [LEN_W-1:0] klen);
    logic [LEN_W:0] t;
    t = {1'b0, n} + (LEN_W+1)'(1);
    if (t > {1'b0, klen}) begin
      return LEN_W'(t - {1'b0, klen});
    end
    return '0;
  endfunction

  always_comb begin
    slen_c = (cfg_i.signal_length > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : cfg_i.signal_length;
    klen_c = (cfg_i.kernel_length > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : cfg_i.kernel_length;
    k_lo   = term_lo(n_q, klen_c);
    k_hi   = (n_q < slen_c) ? n_q : LEN_W'(slen_c - LEN_W'(1));
    empty  = (slen_c == '0) || (klen_c == '0) || (k_lo > k_hi);
    k_end  = empty ? k_lo : k_hi;
    fin    = (k_q == k_end);
    n_nxt  = LEN_W'(n_q + LEN_W'(1));
    j_full = LEN_W'(n_q - k_q);
    accept = start_i && (state_q == ST_IDLE);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && action_i == ACT_COMPUTE && cfg_i.output_length != '0) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (fin && n_q == LEN_W'(cfg_i.output_length - LEN_W'(1))) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o         = '0;
    cmd_o.n       = n_q;
    cmd_o.k_addr  = k_q[ADDR_W-1:0];
    cmd_o.j_addr  = j_full[ADDR_W-1:0];
    cmd_o.first   = (k_q == k_lo);
    cmd_o.fin     = fin;
    cmd_o.zero    = empty;
    cmd_o.lastout = (n_q == LEN_W'(cfg_i.output_length - LEN_W'(1)));
    busy_o        = 1'b1;
    n_d           = n_q;
    k_d           = k_q;
    case (state_q)
      ST_IDLE: begin
        busy_o       = 1'b0;
        cmd_o.wr_sig = accept && (action_i == ACT_LOAD_SIG);
        cmd_o.wr_ker = accept && (action_i == ACT_LOAD_KER);
        n_d          = '0;
        k_d          = term_lo('0, klen_c);
      end
      ST_RUN: begin
        cmd_o.issue = 1'b1;
        if (fin) begin
          n_d = n_nxt;
          k_d = term_lo(n_nxt, klen_c);
        end else begin
          k_d = LEN_W'(k_q + LEN_W'(1));
        end
      end
      ST_DRAIN: begin
        busy_o = 1'b1;
      end
      default: busy_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      k_q     <= k_d;
    end
  end

endmodule

@@ design/flc_datapath.sv @@
// ----------------------------------------------------------------------------
// flc_datapath
// Sample and coefficient stores, multiplier, rescaler and accumulator.
// ----------------------------------------------------------------------------
module flc_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  flc_pkg::flc_cmd_t     cmd_i,
  input  flc_pkg::flc_in_t      in_i,
  input  flc_pkg::flc_cfg_t     cfg_i,
  output flc_pkg::flc_status_t  status_o,
  output logic                  out_valid_o,
  output flc_pkg::flc_out_t     out_o
);
  import flc_pkg::*;

  logic [DATA_W-1:0]        sig_mem [MAX_LEN];
  logic [DATA_W-1:0]        ker_mem [MAX_LEN];
  logic signed [DATA_W-1:0] sig_rd_q, ker_rd_q;
  logic signed [PROD_W-1:0] prod_q, prod_d, bias, biased;
  logic [DATA_W-1:0]        scaled_q, scaled_d, acc_q, sum;
  flc_tag_t                 s1_q, s2_q, s3_q, s1_d;
  logic                     out_valid_q;
  flc_out_t                 out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_sig) begin
      sig_mem[in_i.index] <= in_i.value;
    end
    sig_rd_q <= sig_mem[cmd_i.k_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_ker) begin
      ker_mem[in_i.index] <= in_i.value;
    end
    ker_rd_q <= ker_mem[cmd_i.j_addr];
  end

  always_comb begin
    s1_d.valid   = cmd_i.issue;
    s1_d.first   = cmd_i.first;
    s1_d.fin     = cmd_i.fin;
    s1_d.zero    = cmd_i.zero;
    s1_d.lastout = cmd_i.lastout;
    s1_d.n       = cmd_i.n;
    prod_d   = s1_q.zero ? '0 : PROD_W'(sig_rd_q * ker_rd_q);
    bias     = prod_q[PROD_W-1] ? ((PROD_W'(1) << cfg_i.frac_bits) - PROD_W'(1)) : '0;
    biased   = prod_q + bias;
    scaled_d = DATA_W'(biased >>> cfg_i.frac_bits);
    sum      = (s3_q.first ? '0 : acc_q) + scaled_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= '0;
      s2_q        <= '0;
      s3_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s1_q        <= s1_d;
      s2_q        <= s1_q;
      s3_q        <= s2_q;
      out_valid_q <= s3_q.valid && s3_q.fin;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    scaled_q <= scaled_d;
    if (s3_q.valid) begin
      acc_q <= sum;
    end
    if (s3_q.valid && s3_q.fin) begin
      out_q.out_index <= s3_q.n;
      out_q.out_value <= sum;
      out_q.last      <= s3_q.lastout;
    end
  end

  assign status_o.pipe_busy = s1_q.valid || s2_q.valid || s3_q.valid;
  assign out_valid_o        = out_valid_q;
  assign out_o              = out_q;

endmodule

@@ design/fixed_point_linear_convolution_unit.sv @@
// A load writes its store entry; busy_o stays low and the next command may follow at once.
// A compute command issues each output position's terms in turn, one slot for a position
// with no terms, and then drains; one multiply-accumulate per cycle flows through a 4-stage
// read/multiply/rescale/accumulate pipeline. Results are one-cycle strobes, never stalled.
// Reset returns control and configuration to defaults; stores are undefined until loaded.
// ----------------------------------------------------------------------------
// fixed_point_linear_convolution_unit
// Fixed-point linear convolution of a stored signal with a stored kernel.
// ----------------------------------------------------------------------------
module fixed_point_linear_convolution_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  flc_pkg::flc_in_t              in_i,
  input  logic                          cfg_we_i,
  input  flc_pkg::flc_reg_e             cfg_idx_i,
  input  logic [flc_pkg::CFG_W-1:0]     cfg_wdata_i,
  output logic                          out_valid_o,
  output flc_pkg::flc_out_t             out_o
);
  import flc_pkg::*;

  flc_cfg_t    cfg;
  flc_cmd_t    cmd;
  flc_status_t status;

  flc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  flc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (in_i.action),
    .cfg_i    (cfg),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  flc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_i        (in_i),
    .cfg_i       (cfg),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

endmodule

@@ design/flc_checker.sv @@
// ----------------------------------------------------------------------------
// flc_checker
// Port-level checks of the convolution unit over time.
// ----------------------------------------------------------------------------
module flc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start_i,
  input logic                      busy_o,
  input flc_pkg::flc_in_t          in_i,
  input logic                      cfg_we_i,
  input flc_pkg::flc_reg_e         cfg_idx_i,
  input logic [flc_pkg::CFG_W-1:0] cfg_wdata_i,
  input logic                      out_valid_o,
  input flc_pkg::flc_out_t         out_o
);
  import flc_pkg::*;

  a_out_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy_o)
    else $error("result strobe outside a compute transaction");

  a_busy_from_compute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i) && $past(in_i.action) == ACT_COMPUTE)
    else $error("busy raised without an accepted compute transaction");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.last |=> !out_valid_o && !busy_o)
    else $error("activity after the last result");

  a_first_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o) && $past(busy_o) && !$past(busy_o, 5)
      |-> out_o.out_index == '0)
    else $error("first result of a run is not position zero");

endmodule

bind fixed_point_linear_convolution_unit flc_checker u_flc_checker (.*);

@@ sim/tb_fixed_point_linear_convolution_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_point_linear_convolution_unit
// Self-checking bench for the fixed-point linear convolution unit. Loads
// fill the sample and coefficient stores, compute transactions are predicted
// in the bench and every result strobe is compared field by field in order.
// A short directed part covers extreme values, all actions, ignored items and
// the top rescale shift, then random load/compute sequences, opening with
// saturated lengths, run under several sender idle rates and register settings.
// ----------------------------------------------------------------------------
module tb_fixed_point_linear_convolution_unit;
  import flc_pkg::*;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start_i     = 1'b0;
  logic             busy_o;
  flc_in_t          in_i        = '0;
  logic             cfg_we_i    = 1'b0;
  flc_reg_e         cfg_idx_i   = REG_FRAC_BITS;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             out_valid_o;
  flc_out_t         out_o;

  // bench copy of the block's configuration and stores
  logic [FRAC_W-1:0] frac_q  = 5'd15;
  logic [LEN_W-1:0]  sig_len = '0;
  logic [LEN_W-1:0]  ker_len = '0;
  logic [LEN_W-1:0]  out_len = '0;
  logic [DATA_W-1:0] sig_mem [MAX_LEN];
  logic [DATA_W-1:0] ker_mem [MAX_LEN];
  bit                sig_loaded [MAX_LEN];
  bit                ker_loaded [MAX_LEN];

  flc_in_t  cmd_q [$];
  flc_out_t conv_due_q [$];
  int       idle_pct   = 0;
  int       errors     = 0;
  int       item_count = 0;
  bit       taken      = 1'b0;

  fixed_point_linear_convolution_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [DATA_W-1:0] rescale(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                                logic [FRAC_W-1:0] q);
    logic signed [PROD_W-1:0] p;
    logic [PROD_W-1:0]        mag;
    p   = $signed(a) * $signed(b);
    mag = p[PROD_W-1] ? -p : p;
    mag = mag >> q;
    if (p[PROD_W-1]) mag = -mag;
    return mag[DATA_W-1:0];
  endfunction

  function automatic void predict_convolution();
    int                slen;
    int                klen;
    logic [DATA_W-1:0] acc;
    flc_out_t          r;
    slen = (sig_len > MAX_LEN) ? MAX_LEN : sig_len;
    klen = (ker_len > MAX_LEN) ? MAX_LEN : ker_len;
    for (int n = 0; n < out_len; n++) begin
      acc = '0;
      for (int k = 0; k <= n; k++) begin
        if (k < slen && n - k < klen) acc += rescale(sig_mem[k], ker_mem[n - k], frac_q);
      end
      r.out_index = LEN_W'(n);
      r.out_value = acc;
      r.last      = (n + 1 == out_len);
      conv_due_q.push_back(r);
    end
  endfunction

  // check results, then apply the transaction accepted at this edge
  always @(posedge clk_i) begin
    flc_out_t exp_r;
    taken = rst_ni && start_i && !busy_o;
    if (rst_ni && out_valid_o) begin
      if (conv_due_q.size() == 0) begin
        $error("unexpected result: out_index %0d out_value %0d", out_o.out_index,
               out_o.out_value);
        errors++;
      end else begin
        exp_r = conv_due_q.pop_front();
        if (out_o.out_index !== exp_r.out_index) begin
          $error("out_index: expected %0d, got %0d", exp_r.out_index, out_o.out_index);
          errors++;
        end
        if (out_o.out_value !== exp_r.out_value) begin
          $error("out_value: expected %0d, got %0d", exp_r.out_value, out_o.out_value);
          errors++;
        end
        if (out_o.last !== exp_r.last) begin
          $error("last: expected %0d, got %0d", exp_r.last, out_o.last);
          errors++;
        end
      end
    end
    if (taken) begin
      case (in_i.action)
        ACT_LOAD_SIG: sig_mem[in_i.index] = in_i.value;
        ACT_LOAD_KER: ker_mem[in_i.index] = in_i.value;
        ACT_COMPUTE:  predict_convolution();
        default: ;
      endcase
    end
  end

  // hold start until the transaction is taken, then advance or idle
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!start_i || taken) begin
      if (cmd_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        start_i <= 1'b1;
        in_i    <= cmd_q.pop_front();
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      4, 5: begin
        if ($urandom_range(0, 1)) return 32'($urandom_range(0, 65535));
        return -32'($urandom_range(0, 65535));
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic push_cmd(flc_action_e act, logic [ADDR_W-1:0] idx, logic [DATA_W-1:0] val);
    flc_in_t c;
    c.action = act;
    c.index  = idx;
    c.value  = val;
    cmd_q.push_back(c);
    if (act == ACT_LOAD_SIG) sig_loaded[idx] = 1'b1;
    if (act == ACT_LOAD_KER) ker_loaded[idx] = 1'b1;
    if (act != ACT_NONE) item_count++;
  endtask

  // load every entry the coming compute reads that has never been written
  task automatic push_compute();
    int sreach;
    int kreach;
    sreach = (sig_len > MAX_LEN) ? MAX_LEN : sig_len;
    kreach = (ker_len > MAX_LEN) ? MAX_LEN : ker_len;
    if (sreach > out_len) sreach = out_len;
    if (kreach > out_len) kreach = out_len;
    for (int i = 0; i < sreach; i++) begin
      if (!sig_loaded[i]) push_cmd(ACT_LOAD_SIG, ADDR_W'(i), pick_value());
    end
    for (int i = 0; i < kreach; i++) begin
      if (!ker_loaded[i]) push_cmd(ACT_LOAD_KER, ADDR_W'(i), pick_value());
    end
    push_cmd(ACT_COMPUTE, ADDR_W'($urandom()), $urandom());
  endtask

  task automatic settle();
    do begin
      while (cmd_q.size() != 0 || start_i || conv_due_q.size() != 0 || busy_o)
        @(negedge clk_i);
      repeat (16) @(negedge clk_i);
    end while (busy_o || conv_due_q.size() != 0 || cmd_q.size() != 0);
  endtask

  task automatic write_cfg(logic [FRAC_W-1:0] fb, logic [LEN_W-1:0] sl, logic [LEN_W-1:0] kl,
                           logic [LEN_W-1:0] ol);
    frac_q  = fb;
    sig_len = sl;
    ker_len = kl;
    out_len = ol;
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_FRAC_BITS;
    cfg_wdata_i <= CFG_W'(fb);
    @(negedge clk_i);
    cfg_idx_i   <= REG_SIGNAL_LENGTH;
    cfg_wdata_i <= sl;
    @(negedge clk_i);
    cfg_idx_i   <= REG_KERNEL_LENGTH;
    cfg_wdata_i <= kl;
    @(negedge clk_i);
    cfg_idx_i   <= REG_OUTPUT_LENGTH;
    cfg_wdata_i <= ol;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int               phase;
    int               budget;
    logic [LEN_W-1:0] sl;
    logic [LEN_W-1:0] kl;
    logic [LEN_W-1:0] ol;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: zero output length, ignored action
    push_compute();
    push_cmd(ACT_NONE, 5'd31, 32'hffff_ffff);
    push_cmd(ACT_NONE, 5'd0, 32'd0);
    settle();

    write_cfg(5'd0, 6'd2, 6'd2, 6'd3);
    push_cmd(ACT_LOAD_SIG, 5'd0, 32'h7fff_ffff);
    push_cmd(ACT_LOAD_SIG, 5'd1, 32'h8000_0000);
    push_cmd(ACT_LOAD_KER, 5'd0, 32'h8000_0000);
    push_cmd(ACT_LOAD_KER, 5'd1, 32'hffff_ffff);
    push_compute();
    settle();

    // top shift, then loads at the last store position
    write_cfg(5'd31, 6'd2, 6'd2, 6'd4);
    push_compute();
    push_cmd(ACT_LOAD_SIG, 5'd31, 32'h8000_0000);
    push_cmd(ACT_LOAD_KER, 5'd31, 32'h7fff_ffff);
    settle();

    write_cfg(5'd15, 6'd1, 6'd1, 6'd1);
    push_compute();
    settle();

    write_cfg(5'd30, 6'd0, 6'd2, 6'd2);
    push_compute();
    settle();

    phase      = 0;
    item_count = 0;
    while (item_count < 150) begin
      settle();
      case (phase % 4)
        1:       idle_pct = 46;
        3:       idle_pct = 21;
        default: idle_pct = 0;
      endcase
      if (phase == 0) begin
        write_cfg(5'd30, 6'd63, 6'd63, 6'd63);
      end else begin
        sl = ($urandom_range(0, 7) == 0) ? LEN_W'($urandom_range(32, 63)) :
                                           LEN_W'($urandom_range(0, 8));
        kl = ($urandom_range(0, 7) == 0) ? LEN_W'($urandom_range(32, 63)) :
                                           LEN_W'($urandom_range(0, 8));
        ol = ($urandom_range(0, 7) == 0) ? 6'd63 : LEN_W'($urandom_range(0, 12));
        write_cfg(FRAC_W'($urandom_range(0, 31)), sl, kl, ol);
      end
      budget = item_count + 20;
      while (item_count < budget) begin
        repeat ($urandom_range(0, 4)) begin
          if ($urandom_range(0, 1)) push_cmd(ACT_LOAD_SIG, ADDR_W'($urandom()), pick_value());
          else push_cmd(ACT_LOAD_KER, ADDR_W'($urandom()), pick_value());
        end
        if ($urandom_range(0, 5) == 0) push_cmd(ACT_NONE, ADDR_W'($urandom()), $urandom());
        push_compute();
      end
      phase++;
    end
    settle();

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
